// ----- design/change_event_ring_logger_assert.svh -----
// Assertion macros shared by the change event ring logger RTL.
// The macros expect clk_i and rst_ni to be visible at the place of use.
`ifndef CHANGE_EVENT_RING_LOGGER_ASSERT_SVH
`define CHANGE_EVENT_RING_LOGGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CERL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CERL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cerl_pkg.sv -----
// Package for the change event ring logger: widths, op codes, state codes
// and the item and result structs. No dependencies.
package cerl_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned ENTRY_W    = WORD_W + STAMP_W;

  // Dividend of the slot remainder is head plus count, one bit wider than the count.
  localparam int unsigned DIV_W      = CNT_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(100);

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_RESTART = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_MOD  = 3'b100
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] sample_value;
    logic [31:0]       now_time;
    logic [7:0]        read_slot;
  } item_t;

  typedef struct packed {
    logic               logged;
    logic [7:0]         written_slot;
    logic [8:0]         entry_count;
    logic [7:0]         oldest_slot;
    logic [WORD_W-1:0]  read_value;
    logic [31:0]        read_time;
  } result_t;

endpackage

// ----- design/cerl_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependencies.
module cerl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/change_event_ring_logger.sv -----
// Change event ring logger over cerl_pkg, cerl_ram and change_event_ring_logger_assert.svh.
// Results are registered: sample, restart and clear strobe the cycle after accept; a slot
// read after the read state (RAM read); a sample whose slot needs a full remainder (dividend
// at or above twice the capacity, only after the capacity was lowered) after the remainder
// state; the receiver cannot stall. One item per cycle while idle; busy holds items off
// in a read or remainder. Reset empties the log, sets the capacity to 100, keeps the RAM.
`include "change_event_ring_logger_assert.svh"

module change_event_ring_logger (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  cerl_pkg::item_t            item_i,
  output logic                       done_o,
  output cerl_pkg::result_t          res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cerl_pkg::CNT_W-1:0] cfg_data_i
);

  cerl_pkg::state_e                  state_q, state_d;
  logic [cerl_pkg::CNT_W-1:0]        cap_cfg_q;
  logic [cerl_pkg::CNT_W-1:0]        held_q, held_d;
  logic [cerl_pkg::SLOT_W-1:0]       head_q, head_d;
  logic [cerl_pkg::WORD_W-1:0]       newest_q, newest_d;
  logic                              valid_q, valid_d;
  logic [cerl_pkg::STAMP_W-1:0]      base_q, base_d;
  cerl_pkg::result_t                 res_q, res_d;
  logic                              done_q, done_d;

  // Pending sample for the remainder unit.
  logic [cerl_pkg::WORD_W-1:0]       pend_word_q, pend_word_d;
  logic [cerl_pkg::STAMP_W-1:0]      pend_stamp_q, pend_stamp_d;
  logic                              pend_full_q, pend_full_d;
  logic [cerl_pkg::SLOT_W-1:0]       mod_rem_q, mod_rem_d;
  logic [cerl_pkg::DIV_W-1:0]        mod_num_q, mod_num_d;
  logic [cerl_pkg::DIV_CNT_W-1:0]    mod_cnt_q, mod_cnt_d;

  logic                              accept;
  logic [cerl_pkg::CNT_W-1:0]        cap;
  logic                              restart;
  logic [cerl_pkg::CNT_W-1:0]        e_held;
  logic [cerl_pkg::SLOT_W-1:0]       e_head;
  logic                              e_valid;
  logic [cerl_pkg::STAMP_W-1:0]      e_stamp;
  logic                              e_full;
  logic [cerl_pkg::DIV_W-1:0]        div;
  logic [cerl_pkg::DIV_W-1:0]        div_sub;
  logic [cerl_pkg::CNT_W-1:0]        mod_try;
  logic [cerl_pkg::CNT_W-1:0]        mod_next;
  logic [cerl_pkg::CNT_W-1:0]        head_inc;

  logic                              commit;
  logic [cerl_pkg::SLOT_W-1:0]       c_slot;
  logic                              c_full;
  logic [cerl_pkg::WORD_W-1:0]       c_word;
  logic [cerl_pkg::STAMP_W-1:0]      c_stamp;

  logic                              ram_re;
  logic [cerl_pkg::ENTRY_W-1:0]      ram_rdata;

  assign busy        = (state_q != cerl_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // Effective capacity: zero acts as one, anything above the ring acts as the ring.
  always_comb begin
    if (cap_cfg_q == '0) begin
      cap = cerl_pkg::CNT_W'(1);
    end else if (cap_cfg_q > cerl_pkg::CAP_MAX) begin
      cap = cerl_pkg::CAP_MAX;
    end else begin
      cap = cap_cfg_q;
    end
  end

  // State as seen by a sample; a restart empties the log first.
  assign restart = (item_i.op == cerl_pkg::OP_RESTART);
  assign e_held  = restart ? '0 : held_q;
  assign e_head  = restart ? '0 : head_q;
  assign e_valid = restart ? 1'b0 : valid_q;
  assign e_stamp = restart ? '0 : (item_i.now_time - base_q);
  assign e_full  = (e_held >= cap);
  assign div     = e_full ? {2'b00, e_head}
                          : ({2'b00, e_head} + {1'b0, e_held});
  assign div_sub = div - {1'b0, cap};

  // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
  assign mod_try  = {mod_rem_q, mod_num_q[cerl_pkg::DIV_W-1]};
  assign mod_next = (mod_try >= cap) ? (mod_try - cap) : mod_try;

  // Next state and result.
  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    head_d       = head_q;
    newest_d     = newest_q;
    valid_d      = valid_q;
    base_d       = base_q;
    res_d        = res_q;
    done_d       = 1'b0;
    pend_word_d  = pend_word_q;
    pend_stamp_d = pend_stamp_q;
    pend_full_d  = pend_full_q;
    mod_rem_d    = mod_rem_q;
    mod_num_d    = mod_num_q;
    mod_cnt_d    = mod_cnt_q;
    ram_re       = 1'b0;
    commit       = 1'b0;
    c_slot       = '0;
    c_full       = e_full;
    c_word       = item_i.sample_value;
    c_stamp      = e_stamp;
    head_inc     = '0;

    unique case (state_q)
      cerl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (item_i.op) inside
            cerl_pkg::OP_SAMPLE, cerl_pkg::OP_RESTART: begin
              if (restart) begin
                base_d  = item_i.now_time;
                held_d  = '0;
                head_d  = '0;
                valid_d = 1'b0;
              end
              if (e_valid && (item_i.sample_value == newest_q)) begin
                // Unchanged word: nothing logged.
                res_d  = '{logged: 1'b0, written_slot: '0, entry_count: e_held,
                           oldest_slot: e_head, read_value: '0, read_time: '0};
                done_d = 1'b1;
              end else if (div < {1'b0, cap}) begin
                commit = 1'b1;
                c_slot = div[cerl_pkg::SLOT_W-1:0];
              end else if (div < {cap, 1'b0}) begin
                commit = 1'b1;
                c_slot = div_sub[cerl_pkg::SLOT_W-1:0];
              end else begin
                // Slot needs a full remainder after a capacity change.
                pend_word_d  = item_i.sample_value;
                pend_stamp_d = e_stamp;
                pend_full_d  = e_full;
                mod_rem_d    = '0;
                mod_num_d    = div;
                mod_cnt_d    = '0;
                state_d      = cerl_pkg::ST_MOD;
              end
            end
            cerl_pkg::OP_CLEAR: begin
              held_d = '0;
              head_d = '0;
              res_d  = '{logged: 1'b0, written_slot: '0, entry_count: '0,
                         oldest_slot: '0, read_value: '0, read_time: '0};
              done_d = 1'b1;
            end
            cerl_pkg::OP_READ: begin
              ram_re  = 1'b1;
              state_d = cerl_pkg::ST_READ;
            end
            default: begin
              state_d = cerl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cerl_pkg::ST_READ: begin
        res_d = '{logged: 1'b0, written_slot: '0, entry_count: held_q,
                  oldest_slot: head_q,
                  read_value: ram_rdata[cerl_pkg::ENTRY_W-1:cerl_pkg::STAMP_W],
                  read_time: ram_rdata[cerl_pkg::STAMP_W-1:0]};
        done_d  = 1'b1;
        state_d = cerl_pkg::ST_IDLE;
      end
      cerl_pkg::ST_MOD: begin
        mod_rem_d = mod_next[cerl_pkg::SLOT_W-1:0];
        mod_num_d = {mod_num_q[cerl_pkg::DIV_W-2:0], 1'b0};
        mod_cnt_d = mod_cnt_q + cerl_pkg::DIV_CNT_W'(1);
        if (mod_cnt_q == cerl_pkg::DIV_LAST) begin
          commit  = 1'b1;
          c_slot  = mod_next[cerl_pkg::SLOT_W-1:0];
          c_full  = pend_full_q;
          c_word  = pend_word_q;
          c_stamp = pend_stamp_q;
          state_d = cerl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cerl_pkg::ST_IDLE;
      end
    endcase

    // Logging an entry: advance count or head and report the slot.
    if (commit) begin
      valid_d  = 1'b1;
      newest_d = c_word;
      if (c_full) begin
        head_inc = {1'b0, c_slot} + cerl_pkg::CNT_W'(1);
        head_d   = (head_inc == cap) ? '0 : head_inc[cerl_pkg::SLOT_W-1:0];
      end else begin
        held_d = held_d + cerl_pkg::CNT_W'(1);
      end
      res_d  = '{logged: 1'b1, written_slot: c_slot, entry_count: held_d,
                 oldest_slot: head_d, read_value: '0, read_time: '0};
      done_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cerl_pkg::ST_IDLE;
      cap_cfg_q <= cerl_pkg::CAP_RESET;
      held_q    <= '0;
      head_q    <= '0;
      newest_q  <= '0;
      valid_q   <= 1'b0;
      base_q    <= '0;
      done_q    <= 1'b0;
      mod_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      head_q   <= head_d;
      newest_q <= newest_d;
      valid_q  <= valid_d;
      base_q   <= base_d;
      done_q   <= done_d;
      mod_cnt_q <= mod_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_cfg_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    pend_word_q  <= pend_word_d;
    pend_stamp_q <= pend_stamp_d;
    pend_full_q  <= pend_full_d;
    mod_rem_q    <= mod_rem_d;
    mod_num_q    <= mod_num_d;
  end

  // Event store: word and relative time per slot.
  cerl_ram #(
    .WIDTH(cerl_pkg::ENTRY_W),
    .DEPTH(cerl_pkg::RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (c_slot),
    .wdata_i ({c_word, c_stamp}),
    .re_i    (ram_re),
    .raddr_i (item_i.read_slot),
    .rdata_o (ram_rdata)
  );

  `CERL_ASSERT_IMP(a_done_when_idle, done_q, !busy, "result strobed while busy")
  `CERL_ASSERT_NXT(a_read_issues, accept && (item_i.op == cerl_pkg::OP_READ), state_q == cerl_pkg::ST_READ, "read item did not enter read state")
  `CERL_ASSERT_NXT(a_read_done, state_q == cerl_pkg::ST_READ, done_q && !res_q.logged, "read item gave no result")
  `CERL_ASSERT_NXT(a_mod_done, (state_q == cerl_pkg::ST_MOD) && (mod_cnt_q == cerl_pkg::DIV_LAST), done_q && res_q.logged, "remainder path did not log")
  `CERL_ASSERT_IMP(a_held_bound, 1'b1, held_q <= cerl_pkg::CAP_MAX, "held count beyond ring depth")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for change_event_ring_logger: directed cases, then random traffic
// over a series of ring capacities, each result checked against an in-bench predictor.
// Depends on cerl_pkg and the change_event_ring_logger RTL.
module tb;

  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES = 14;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  cerl_pkg::item_t            item_i;
  logic                       done_o;
  cerl_pkg::result_t          res_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [cerl_pkg::CNT_W-1:0] cfg_data_i;

  change_event_ring_logger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Predicted logger state, mirrored item by item.
  logic [cerl_pkg::WORD_W-1:0]  ring_words   [cerl_pkg::RING_DEPTH];
  logic [cerl_pkg::STAMP_W-1:0] ring_stamps  [cerl_pkg::RING_DEPTH];
  bit                           ring_written [cerl_pkg::RING_DEPTH];
  int unsigned                  written_slots [$];
  int unsigned                  held_n       = 0;
  int unsigned                  head_n       = 0;
  logic [cerl_pkg::WORD_W-1:0]  last_word    = '0;
  bit                           last_valid   = 1'b0;
  logic [cerl_pkg::STAMP_W-1:0] base_time    = '0;
  logic [cerl_pkg::CNT_W-1:0]   capacity_reg = cerl_pkg::CAP_RESET;

  // Status results still owed by the logger, oldest first.
  cerl_pkg::result_t log_status_q [$];

  int unsigned mismatches = 0;
  int unsigned n_items    = 0;
  int unsigned n_reads    = 0;
  int unsigned n_logged   = 0;
  int unsigned n_caps     = 0;
  int          burst_left = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stores a word if it differs from the newest one; returns 1 and the slot when it writes.
  function automatic bit log_word(logic [cerl_pkg::WORD_W-1:0] w, logic [31:0] now,
                                  output int unsigned slot);
    int unsigned cap;
    cap  = 32'(capacity_reg);
    slot = 0;
    if (cap == 0) cap = 1;
    if (cap > cerl_pkg::RING_DEPTH) cap = cerl_pkg::RING_DEPTH;
    if (last_valid && w == last_word) return 1'b0;
    if (held_n < cap) begin
      slot   = (head_n + held_n) % cap;
      held_n = held_n + 1;
    end else begin
      slot   = head_n % cap;
      head_n = (head_n + 1) % cap;
    end
    ring_words[slot[7:0]]  = w;
    ring_stamps[slot[7:0]] = now - base_time;
    if (!ring_written[slot[7:0]]) begin
      ring_written[slot[7:0]] = 1'b1;
      written_slots.push_back(slot);
    end
    last_word  = w;
    last_valid = 1'b1;
    return 1'b1;
  endfunction

  // Works out the status result that one accepted item produces.
  function automatic cerl_pkg::result_t predict_status(cerl_pkg::item_t it);
    cerl_pkg::result_t r;
    int unsigned       slot;
    bit                wrote;
    r     = '0;
    slot  = 0;
    wrote = 1'b0;
    case (it.op)
      cerl_pkg::OP_SAMPLE: begin
        wrote = log_word(it.sample_value, it.now_time, slot);
      end
      cerl_pkg::OP_RESTART: begin
        base_time  = it.now_time;
        held_n     = 0;
        head_n     = 0;
        last_valid = 1'b0;
        wrote      = log_word(it.sample_value, it.now_time, slot);
      end
      cerl_pkg::OP_CLEAR: begin
        held_n = 0;
        head_n = 0;
      end
      default: begin
        r.read_value = ring_words[it.read_slot];
        r.read_time  = ring_stamps[it.read_slot];
      end
    endcase
    r.logged       = wrote;
    r.written_slot = wrote ? slot[7:0] : 8'd0;
    r.entry_count  = held_n[8:0];
    r.oldest_slot  = head_n[7:0];
    return r;
  endfunction

  function automatic cerl_pkg::item_t mk(cerl_pkg::op_e op, logic [cerl_pkg::WORD_W-1:0] w,
                                         logic [31:0] t, logic [7:0] s);
    cerl_pkg::item_t it;
    it.op           = op;
    it.sample_value = w;
    it.now_time     = t;
    it.read_slot    = s;
    return it;
  endfunction

  // Random item; reads only target slots that have been written.
  function automatic cerl_pkg::item_t random_item(int unsigned restart_pct,
                                                  int unsigned read_pct);
    cerl_pkg::item_t it;
    int unsigned     roll;
    it.sample_value = {$urandom(), $urandom()};
    it.now_time     = $urandom();
    it.read_slot    = 8'($urandom_range(0, 255));
    roll            = $urandom_range(0, 99);
    if (roll < restart_pct) begin
      it.op = cerl_pkg::OP_RESTART;
    end else if (roll < 2 * restart_pct) begin
      it.op = cerl_pkg::OP_CLEAR;
    end else if (roll < 2 * restart_pct + read_pct && written_slots.size() != 0) begin
      it.op        = cerl_pkg::OP_READ;
      it.read_slot = 8'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    end else begin
      it.op = cerl_pkg::OP_SAMPLE;
    end
    // Repeated words must not log; the all-zero and all-one words are the extremes.
    case ($urandom_range(0, 19))
      0:       it.sample_value = '0;
      1:       it.sample_value = '1;
      2, 3, 4: it.sample_value = last_word;
      default: ;
    endcase
    return it;
  endfunction

  // Sender pacing: bursts of random length with random gaps in between.
  task automatic pace();
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
    end
    burst_left--;
  endtask

  // Offers one item and waits for the logger to take it.
  task automatic send_item(cerl_pkg::item_t it);
    pace();
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    log_status_q.push_back(predict_status(it));
    n_items++;
    if (it.op == cerl_pkg::OP_READ) n_reads++;
  endtask

  // Holds off until every owed result has come, then lets the logger settle.
  task automatic wait_drain();
    start <= 1'b0;
    while (log_status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [cerl_pkg::CNT_W-1:0] v);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    capacity_reg = v;
    n_caps++;
  endtask

  // The first sample after reset logs even when it equals the reset word.
  task automatic test_first_sample();
    send_item(mk(cerl_pkg::OP_SAMPLE, '0, 32'd5, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, '0, 32'd6, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, '1, 32'hFFFF_FFFF, 8'hFF));
  endtask

  // Clear empties the log but keeps the newest word.
  task automatic test_clear_keeps_word();
    send_item(mk(cerl_pkg::OP_CLEAR, 64'h0123_4567_89AB_CDEF, 32'd10, 8'h5A));
    send_item(mk(cerl_pkg::OP_SAMPLE, '1, 32'd11, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'd1, 32'd12, 8'd0));
  endtask

  // Restart always logs at slot 0 with time 0; stamps wrap modulo 2^32.
  task automatic test_restart();
    send_item(mk(cerl_pkg::OP_RESTART, 64'd1, 32'hFFFF_FFF0, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'd1, 32'h0000_0004, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h8000_0000_0000_0000, 32'h0000_0010, 8'd0));
  endtask

  task automatic test_slot_reads();
    send_item(mk(cerl_pkg::OP_READ, '0, 32'd0, 8'd0));
    send_item(mk(cerl_pkg::OP_READ, '1, 32'hFFFF_FFFF, 8'd1));
  endtask

  // Capacity zero acts as one, above the depth acts as the depth, and a lowered
  // capacity with more events held counts as full.
  task automatic test_capacity_edges();
    write_capacity(9'd0);
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'hA5A5, 32'd100, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h5A5A, 32'd101, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'hFFFF, 32'd102, 8'd0));
    send_item(mk(cerl_pkg::OP_READ, '0, 32'd0, 8'd0));
    write_capacity(9'd511);
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h1111, 32'd200, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h2222, 32'd201, 8'd0));
    write_capacity(9'd2);
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h3333, 32'd300, 8'd0));
    send_item(mk(cerl_pkg::OP_SAMPLE, 64'h4444, 32'd301, 8'd0));
  endtask

  // Random traffic in phases, one ring capacity per phase. The first phase fills the
  // whole ring and wraps; the next lowers the capacity while the ring is full.
  task automatic test_random_traffic();
    int unsigned caps    [12] = '{256, 7, 511, 0, 200, 3, 257, 1, 100, 2, 0, 0};
    int unsigned lens    [12] = '{420, 60, 60, 40, 80, 60, 60, 40, 80, 40, 60, 60};
    int unsigned restarts[12] = '{0, 0, 3, 2, 2, 3, 0, 3, 3, 2, 1, 4};
    caps[10] = $urandom_range(1, 511);
    caps[11] = $urandom_range(1, 511);
    for (int p = 0; p < 12; p++) begin
      write_capacity(cerl_pkg::CNT_W'(caps[p]));
      for (int unsigned k = 0; k < lens[p]; k++) begin
        if ($urandom_range(0, 99) == 0) wait_drain();
        send_item(random_item(restarts[p], (p == 0) ? 8 : 20));
      end
    end
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Compares each strobed result with the oldest owed one.
  always @(posedge clk_i) begin : status_check
    cerl_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (log_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: result with none owed, expected nothing, got %0h", $time, res_o);
      end else begin
        want = log_status_q.pop_front();
        check_field("logged",       64'(want.logged),       64'(res_o.logged));
        check_field("written_slot", 64'(want.written_slot), 64'(res_o.written_slot));
        check_field("entry_count",  64'(want.entry_count),  64'(res_o.entry_count));
        check_field("oldest_slot",  64'(want.oldest_slot),  64'(res_o.oldest_slot));
        check_field("read_value",   want.read_value,        res_o.read_value);
        check_field("read_time",    64'(want.read_time),    64'(res_o.read_time));
        if (res_o.logged === 1'b1) n_logged++;
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAIL change_event_ring_logger");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_clear_keeps_word();
    test_restart();
    test_slot_reads();
    test_capacity_edges();
    test_random_traffic();
    wait_drain();
    $display("Covered %0d items: %0d events logged, %0d slot reads, %0d capacity settings.",
             n_items, n_logged, n_reads, n_caps);
    if (mismatches == 0) begin
      $display("PASS change_event_ring_logger");
    end else begin
      $display("FAIL change_event_ring_logger");
    end
    $finish;
  end

endmodule
